// File: hw/rtl/svm_pkg.sv
// Shared types, constants and the per-sextant phase sign table of the space
// vector modulator. No dependencies.
`default_nettype none

package svm_pkg;

  // Field widths
  localparam int unsigned IN_W     = 16;
  localparam int unsigned DUTY_W   = 15;
  localparam int unsigned SECTOR_W = 3;

  // Scaled alpha and beta products (48 bits) and dwell times (one bit more)
  localparam int unsigned PROD_W   = 48;
  localparam int unsigned DWELL_W  = PROD_W + 1;

  // Default fraction bits of the input format
  localparam int unsigned FRAC_BITS_DEF = 14;

  // Output duty scale: 1.0 = 2^OUT_FRAC
  localparam int unsigned OUT_FRAC = 14;
  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(1) << OUT_FRAC;

  // Approximately 2^32 / sqrt(3)
  localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700526;

  // Sextant codes, numbered as on the output port
  typedef enum logic [SECTOR_W-1:0] {
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5,
    SECTOR_6 = 3'd6
  } sector_e;

  // Each doubled duty is one +/- ta +/- tb; a set bit negates that term
  typedef struct packed {
    logic neg_ta;
    logic neg_tb;
  } phase_sign_t;

  typedef struct packed {
    phase_sign_t a;
    phase_sign_t b;
    phase_sign_t c;
  } signs_t;

  // Scaled vector after the multiplier stage
  typedef struct packed {
    logic signed [PROD_W-1:0] a;
    logic signed [PROD_W-1:0] b;
  } prod_t;

  // Dwell stage result
  typedef struct packed {
    logic signed [DWELL_W-1:0] ta;
    logic signed [DWELL_W-1:0] tb;
    sector_e                   sector;
    signs_t                    signs;
  } dwell_t;

  // Per-sextant term signs: the leading phase gets one - ta - tb, the
  // trailing phase one + ta + tb, the middle phase one of the mixed forms.
  function automatic signs_t phase_signs(sector_e sector);
    signs_t s;
    s = '0;
    unique case (sector)
      SECTOR_1: begin
        s.a = '{1'b1, 1'b1}; s.b = '{1'b0, 1'b1}; s.c = '{1'b0, 1'b0};
      end
      SECTOR_2: begin
        s.b = '{1'b1, 1'b1}; s.a = '{1'b1, 1'b0}; s.c = '{1'b0, 1'b0};
      end
      SECTOR_3: begin
        s.b = '{1'b1, 1'b1}; s.c = '{1'b0, 1'b1}; s.a = '{1'b0, 1'b0};
      end
      SECTOR_4: begin
        s.c = '{1'b1, 1'b1}; s.b = '{1'b1, 1'b0}; s.a = '{1'b0, 1'b0};
      end
      SECTOR_5: begin
        s.c = '{1'b1, 1'b1}; s.a = '{1'b0, 1'b1}; s.b = '{1'b0, 1'b0};
      end
      SECTOR_6: begin
        s.a = '{1'b1, 1'b1}; s.c = '{1'b1, 1'b0}; s.b = '{1'b0, 1'b0};
      end
      default: begin
        s = '0;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/space_vector_modulator.sv
// Space vector modulator top level: handshake, pipeline registers and the
// multiplier stage. Depends on svm_pkg, svm_dwell and svm_duty.
//
// Usage:
//   A request carries alpha_norm_i and beta_norm_i (signed, 1.0 = 2^FRAC_BITS)
//   and is taken when in_valid_i is high and in_stall_o low. Each request
//   gives exactly one result: three phase duties (unsigned, 16384 = 1.0,
//   saturated to 0..1) and the sextant number 1..6, offered on out_valid_o
//   and taken when out_stall_i is low.
//   Path: the request is caught in the input register, then passes the
//   beta/sqrt3 multiply, the sextant and dwell stage and the duty and
//   rounding stage, one register each.
//   Throughput: one request per cycle while the receiver does not stall; the
//   four stages work on different requests at the same time.
//   Stalls: a stalled result holds on the outputs. Empty stages keep filling
//   behind it, and in_stall_o rises only when all four stages hold requests
//   and the receiver stalls.
//   Reset: asynchronous, active low; clears all stage valids, no result is
//   offered after reset. The payload registers are not reset.
`default_nettype none

module space_vector_modulator #(
  parameter int unsigned FRAC_BITS = svm_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [svm_pkg::IN_W-1:0]      alpha_norm_i,
  input  logic signed [svm_pkg::IN_W-1:0]      beta_norm_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [svm_pkg::DUTY_W-1:0]    duty_phase_a_o,
  output logic        [svm_pkg::DUTY_W-1:0]    duty_phase_b_o,
  output logic        [svm_pkg::DUTY_W-1:0]    duty_phase_c_o,
  output logic        [svm_pkg::SECTOR_W-1:0]  sector_number_o
);
  import svm_pkg::*;

  // Stage valids and advance enables
  logic v0_q, v1_q, v2_q, v3_q;
  logic en0, en1, en2, en3;

  // Stage payloads
  logic signed [IN_W-1:0]   alpha_q;
  logic signed [IN_W-1:0]   beta_q;
  prod_t                    prod_d, prod_q;
  dwell_t                   dwell_d, dwell_q;
  logic        [DUTY_W-1:0] duty_a_d, duty_b_d, duty_c_d;
  logic        [DUTY_W-1:0] duty_a_q, duty_b_q, duty_c_q;
  sector_e                  sector_q;
  logic signed [PROD_W:0]   beta_scaled;

  // A stage advances when it is empty or the next one advances
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign in_stall_o = !en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Multiplier stage: alpha scaled by 2^32, beta by 2^32/sqrt3
  assign beta_scaled = beta_q * $signed({1'b0, INV_SQRT3_Q32});
  assign prod_d.a    = {alpha_q, 32'b0};
  assign prod_d.b    = beta_scaled[PROD_W-1:0];

  // Sextant and dwell times
  svm_dwell u_dwell (
    .prod_i  (prod_q),
    .dwell_o (dwell_d)
  );

  // Phase duties
  svm_duty #(.FRAC_BITS(FRAC_BITS)) u_duty_a (
    .ta_i   (dwell_q.ta),
    .tb_i   (dwell_q.tb),
    .sign_i (dwell_q.signs.a),
    .duty_o (duty_a_d)
  );

  svm_duty #(.FRAC_BITS(FRAC_BITS)) u_duty_b (
    .ta_i   (dwell_q.ta),
    .tb_i   (dwell_q.tb),
    .sign_i (dwell_q.signs.b),
    .duty_o (duty_b_d)
  );

  svm_duty #(.FRAC_BITS(FRAC_BITS)) u_duty_c (
    .ta_i   (dwell_q.ta),
    .tb_i   (dwell_q.tb),
    .sign_i (dwell_q.signs.c),
    .duty_o (duty_c_d)
  );

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (en0) begin
      alpha_q <= alpha_norm_i;
      beta_q  <= beta_norm_i;
    end
    if (en1) prod_q  <= prod_d;
    if (en2) dwell_q <= dwell_d;
    if (en3) begin
      duty_a_q <= duty_a_d;
      duty_b_q <= duty_b_d;
      duty_c_q <= duty_c_d;
      sector_q <= dwell_q.sector;
    end
  end

  assign out_valid_o     = v3_q;
  assign duty_phase_a_o  = duty_a_q;
  assign duty_phase_b_o  = duty_b_q;
  assign duty_phase_c_o  = duty_c_q;
  assign sector_number_o = sector_q;

endmodule

`default_nettype wire

// File: hw/rtl/svm_dwell.sv
// Sextant decision and active dwell times from the scaled vector.
// Depends on svm_pkg.
`default_nettype none

module svm_dwell (
  input  svm_pkg::prod_t  prod_i,
  output svm_pkg::dwell_t dwell_o
);
  import svm_pkg::*;

  logic signed [DWELL_W-1:0] ax;
  logic signed [DWELL_W-1:0] bx;
  logic signed [DWELL_W-1:0] neg_b;
  logic signed [DWELL_W-1:0] sum_ab;
  logic signed [DWELL_W-1:0] diff_ab;
  logic signed [DWELL_W-1:0] dbl_b;
  logic                      b_gt_a;
  logic                      nb_gt_a;
  sector_e                   sector;

  // Candidate terms, all formed in parallel with the compares
  assign ax      = {prod_i.a[PROD_W-1], prod_i.a};
  assign bx      = {prod_i.b[PROD_W-1], prod_i.b};
  assign neg_b   = -bx;
  assign sum_ab  = ax + bx;
  assign diff_ab = ax - bx;
  assign dbl_b   = {prod_i.b, 1'b0};
  assign b_gt_a  = bx > ax;
  assign nb_gt_a = neg_b > ax;

  // Sextant from the signs of alpha and beta and the beta/sqrt3 compare
  always_comb begin
    if (!prod_i.b[PROD_W-1]) begin
      if (!prod_i.a[PROD_W-1]) begin
        sector = b_gt_a ? SECTOR_2 : SECTOR_1;
      end else begin
        sector = nb_gt_a ? SECTOR_3 : SECTOR_2;
      end
    end else begin
      if (!prod_i.a[PROD_W-1]) begin
        sector = nb_gt_a ? SECTOR_5 : SECTOR_6;
      end else begin
        sector = b_gt_a ? SECTOR_4 : SECTOR_5;
      end
    end
  end

  // Active dwell times of the sextant
  always_comb begin
    dwell_o.sector = sector;
    dwell_o.signs  = phase_signs(sector);
    unique case (sector)
      SECTOR_1: begin
        dwell_o.ta = diff_ab;  dwell_o.tb = dbl_b;
      end
      SECTOR_2: begin
        dwell_o.ta = sum_ab;   dwell_o.tb = -diff_ab;
      end
      SECTOR_3: begin
        dwell_o.ta = dbl_b;    dwell_o.tb = -sum_ab;
      end
      SECTOR_4: begin
        dwell_o.ta = -diff_ab; dwell_o.tb = -dbl_b;
      end
      SECTOR_5: begin
        dwell_o.ta = -sum_ab;  dwell_o.tb = diff_ab;
      end
      SECTOR_6: begin
        dwell_o.ta = -dbl_b;   dwell_o.tb = sum_ab;
      end
      default: begin
        dwell_o.ta = '0;       dwell_o.tb = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/svm_duty.sv
// One phase duty: centred sum of the dwell terms, saturated to 0..1 and
// rounded to the output scale. Depends on svm_pkg.
`default_nettype none

module svm_duty #(
  parameter int unsigned FRAC_BITS = svm_pkg::FRAC_BITS_DEF
) (
  input  logic signed [svm_pkg::DWELL_W-1:0] ta_i,
  input  logic signed [svm_pkg::DWELL_W-1:0] tb_i,
  input  svm_pkg::phase_sign_t               sign_i,
  output logic        [svm_pkg::DUTY_W-1:0]  duty_o
);
  import svm_pkg::*;

  // Room for one (2^(FRAC_BITS+32)), the dwell terms and the full-scale limit
  localparam int unsigned BASE_W = (FRAC_BITS + 32 > 50) ? FRAC_BITS + 32 : 50;
  localparam int unsigned SUM_W  = BASE_W + 3;
  localparam int unsigned SHIFT  = FRAC_BITS + 33 - OUT_FRAC;

  localparam logic [SUM_W-1:0] ONE  = SUM_W'(1) << (FRAC_BITS + 32);
  localparam logic [SUM_W-1:0] FULL = SUM_W'(1) << (FRAC_BITS + 33);
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);

  logic signed [SUM_W-1:0] ta_x;
  logic signed [SUM_W-1:0] tb_x;
  logic signed [SUM_W-1:0] term_a;
  logic signed [SUM_W-1:0] term_b;
  logic signed [SUM_W-1:0] sum;
  logic        [SUM_W-1:0] rnd;

  assign ta_x   = {{(SUM_W-DWELL_W){ta_i[DWELL_W-1]}}, ta_i};
  assign tb_x   = {{(SUM_W-DWELL_W){tb_i[DWELL_W-1]}}, tb_i};
  assign term_a = sign_i.neg_ta ? -ta_x : ta_x;
  assign term_b = sign_i.neg_tb ? -tb_x : tb_x;
  assign sum    = $signed(ONE) + term_a + term_b;
  assign rnd    = sum + HALF;

  // Saturate below zero and above full scale, else round half up
  always_comb begin
    if (sum[SUM_W-1]) begin
      duty_o = '0;
    end else if (sum > $signed(FULL)) begin
      duty_o = DUTY_MAX;
    end else begin
      duty_o = rnd[SHIFT+DUTY_W-1:SHIFT];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/svm_checker.sv
// Port-level checks for the space vector modulator, bound to the top level.
// Depends on svm_pkg.
`default_nettype none

module svm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [svm_pkg::DUTY_W-1:0]         duty_phase_a_o,
  input logic [svm_pkg::DUTY_W-1:0]         duty_phase_b_o,
  input logic [svm_pkg::DUTY_W-1:0]         duty_phase_c_o,
  input logic [svm_pkg::SECTOR_W-1:0]       sector_number_o
);
  import svm_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Requests are held back only when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // Sextant number is one of 1..6
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sector_number_o >= SECTOR_W'(SECTOR_1) &&
                    sector_number_o <= SECTOR_W'(SECTOR_6))
    else $error("sextant out of range");

  // Duties never exceed full scale
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_phase_a_o <= DUTY_MAX && duty_phase_b_o <= DUTY_MAX &&
                    duty_phase_c_o <= DUTY_MAX)
    else $error("duty above full scale");

endmodule

bind space_vector_modulator svm_checker u_svm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .duty_phase_a_o  (duty_phase_a_o),
  .duty_phase_b_o  (duty_phase_b_o),
  .duty_phase_c_o  (duty_phase_c_o),
  .sector_number_o (sector_number_o)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for space_vector_modulator: directed and random vectors,
// with duties and sextant predicted in exact 64-bit fixed point.
// Depends on svm_pkg and the space_vector_modulator RTL.
`default_nettype none

module tb_top;
  import svm_pkg::*;

  // Run limits
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_PRINTED   = 20;

  // Fixed-point units of the duty arithmetic: 1.0 = 2^(FRAC_BITS_DEF+32)
  localparam longint UNIT_ONE   = 64'sd1 <<< (FRAC_BITS_DEF + 32);
  localparam longint DOUBLE_MAX = 64'sd1 <<< (FRAC_BITS_DEF + 33);
  localparam int     ROUND_SH   = FRAC_BITS_DEF + 33 - OUT_FRAC;
  localparam longint BETA_GAIN  = longint'(INV_SQRT3_Q32);
  localparam real    SQRT3      = 1.7320508075688772;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    sector_e           sector;
  } duties_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [IN_W-1:0]    alpha_norm_i;
  logic signed [IN_W-1:0]    beta_norm_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [DUTY_W-1:0]         duty_phase_a_o;
  logic [DUTY_W-1:0]         duty_phase_b_o;
  logic [DUTY_W-1:0]         duty_phase_c_o;
  logic [SECTOR_W-1:0]       sector_number_o;

  duties_t pending_duties[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      sent_count;
  int      checked_count = 0;
  int      stall_left = 0;
  int      sector_hits[7] = '{default: 0};
  bit      idling_on;

  space_vector_modulator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .alpha_norm_i    (alpha_norm_i),
    .beta_norm_i     (beta_norm_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .duty_phase_a_o  (duty_phase_a_o),
    .duty_phase_b_o  (duty_phase_b_o),
    .duty_phase_c_o  (duty_phase_c_o),
    .sector_number_o (sector_number_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Doubled duty to output scale: clamp to 0..1, round to nearest, ties up
  function automatic logic [DUTY_W-1:0] scale_duty(longint doubled);
    longint clamped;
    if (doubled < 0) begin
      return '0;
    end
    clamped = (doubled > DOUBLE_MAX) ? DOUBLE_MAX : doubled;
    return DUTY_W'((clamped + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH);
  endfunction

  // Sextant choice, dwell times and centred duties for one vector
  function automatic duties_t predict_duties(logic signed [IN_W-1:0] alpha,
                                             logic signed [IN_W-1:0] beta);
    longint  a_s;
    longint  b_s;
    longint  ta;
    longint  tb;
    longint  da;
    longint  db;
    longint  dc;
    duties_t res;
    a_s = longint'(alpha) <<< 32;
    b_s = longint'(beta) * BETA_GAIN;
    if (beta >= 0) begin
      if (alpha >= 0) res.sector = (b_s > a_s) ? SECTOR_2 : SECTOR_1;
      else            res.sector = (-b_s > a_s) ? SECTOR_3 : SECTOR_2;
    end else begin
      if (alpha >= 0) res.sector = (-b_s > a_s) ? SECTOR_5 : SECTOR_6;
      else            res.sector = (b_s > a_s) ? SECTOR_4 : SECTOR_5;
    end
    // Phase order per sextant as the block defines it
    case (res.sector)
      SECTOR_1: begin
        ta = a_s - b_s; tb = 2 * b_s;
        da = UNIT_ONE - ta - tb; db = da + 2 * ta; dc = db + 2 * tb;
      end
      SECTOR_2: begin
        ta = a_s + b_s; tb = -a_s + b_s;
        db = UNIT_ONE - ta - tb; da = db + 2 * tb; dc = da + 2 * ta;
      end
      SECTOR_3: begin
        ta = 2 * b_s; tb = -a_s - b_s;
        db = UNIT_ONE - ta - tb; dc = db + 2 * ta; da = dc + 2 * tb;
      end
      SECTOR_4: begin
        ta = -a_s + b_s; tb = -2 * b_s;
        dc = UNIT_ONE - ta - tb; db = dc + 2 * tb; da = db + 2 * ta;
      end
      SECTOR_5: begin
        ta = -a_s - b_s; tb = a_s - b_s;
        dc = UNIT_ONE - ta - tb; da = dc + 2 * ta; db = da + 2 * tb;
      end
      default: begin
        ta = -2 * b_s; tb = a_s + b_s;
        da = UNIT_ONE - ta - tb; dc = da + 2 * tb; db = dc + 2 * ta;
      end
    endcase
    res.duty_a = scale_duty(da);
    res.duty_b = scale_duty(db);
    res.duty_c = scale_duty(dc);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < MAX_PRINTED) begin
      $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  // Send one request; valid stays high unless a gap follows
  task automatic send_vector(logic signed [IN_W-1:0] alpha, logic signed [IN_W-1:0] beta);
    int gap;
    gap = idling_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    alpha_norm_i <= alpha;
    beta_norm_i  <= beta;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_duties.push_back(predict_duties(alpha, beta));
    sent_count++;
  endtask

  // Result check and receiver stall
  always @(posedge clk_i) begin
    duties_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_duties.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_duties.pop_front();
        if (duty_phase_a_o !== want.duty_a)
          report_mismatch("duty_phase_a", duty_phase_a_o, want.duty_a);
        if (duty_phase_b_o !== want.duty_b)
          report_mismatch("duty_phase_b", duty_phase_b_o, want.duty_b);
        if (duty_phase_c_o !== want.duty_c)
          report_mismatch("duty_phase_c", duty_phase_c_o, want.duty_c);
        if (sector_number_o !== want.sector)
          report_mismatch("sector_number", sector_number_o, want.sector);
        sector_hits[want.sector]++;
      end
      checked_count++;
      stall_left = idling_on ? $urandom_range(0, 10) : 0;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Full-scale corners and axis ends, zero and the smallest non-zero vectors
  task automatic test_extremes();
    send_vector(16'sd0, 16'sd0);
    send_vector(16'sd32767, 16'sd32767);
    send_vector(-16'sd32768, -16'sd32768);
    send_vector(16'sd32767, -16'sd32768);
    send_vector(-16'sd32768, 16'sd32767);
    send_vector(16'sd32767, 16'sd0);
    send_vector(-16'sd32768, 16'sd0);
    send_vector(16'sd0, 16'sd32767);
    send_vector(16'sd0, -16'sd32768);
    send_vector(16'sd1, -16'sd1);
    send_vector(-16'sd1, 16'sd1);
    send_vector(-16'sd1, -16'sd1);
    send_vector(16'sd1, 16'sd1);
  endtask

  // Near the 60 degree lines (both sides at 60, 120), then one per sextant centre
  task automatic test_sextants();
    send_vector(16'sd8192, 16'sd14189);
    send_vector(16'sd8192, 16'sd14188);
    send_vector(-16'sd8192, 16'sd14189);
    send_vector(-16'sd8192, 16'sd14188);
    send_vector(16'sd8192, -16'sd14189);
    send_vector(-16'sd8192, -16'sd14189);
    send_vector(16'sd7094, 16'sd4096);
    send_vector(16'sd0, 16'sd8192);
    send_vector(-16'sd7094, 16'sd4096);
    send_vector(-16'sd7094, -16'sd4096);
    send_vector(16'sd0, -16'sd8192);
    send_vector(16'sd7094, -16'sd4096);
  endtask

  // Mostly in-hexagon vectors, some full-range, some hugging sextant edges, some near zero
  task automatic test_random_vectors();
    int                     kind;
    int                     mag;
    int                     bmag;
    logic signed [IN_W-1:0] alpha;
    logic signed [IN_W-1:0] beta;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // stretches of 150 vectors; every third, from the second on, runs without idling
      if (n % 150 == 0) idling_on = ((n / 150) % 3 != 1);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        alpha = IN_W'($signed($urandom_range(0, 37836)) - 18918);
        beta  = IN_W'($signed($urandom_range(0, 37836)) - 18918);
      end else if (kind < 80) begin
        alpha = IN_W'($urandom);
        beta  = IN_W'($urandom);
      end else if (kind < 92) begin
        mag  = $urandom_range(0, 18918);
        bmag = int'(mag * SQRT3) + $signed($urandom_range(0, 6)) - 3;
        if (bmag < 0) bmag = 0;
        if (bmag > 32767) bmag = 32767;
        alpha = $urandom_range(0, 1) ? IN_W'(-mag) : IN_W'(mag);
        beta  = $urandom_range(0, 1) ? IN_W'(-bmag) : IN_W'(bmag);
      end else begin
        alpha = IN_W'($signed($urandom_range(0, 64)) - 32);
        beta  = IN_W'($signed($urandom_range(0, 64)) - 32);
      end
      send_vector(alpha, beta);
    end
  endtask

  // Stop sending and let the pipeline empty
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    alpha_norm_i = '0;
    beta_norm_i  = '0;
    sent_count   = 0;
    idling_on    = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_sextants();
    test_random_vectors();
    drain_results();

    $display("Sent %0d vectors, compared %0d results in %0d cycles.",
             sent_count, checked_count, cycle_count);
    $display("Sextant hits 1..6: %0d %0d %0d %0d %0d %0d", sector_hits[1], sector_hits[2],
             sector_hits[3], sector_hits[4], sector_hits[5], sector_hits[6]);
    if (error_count == 0 && pending_duties.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/svm_pkg.sv
hw/rtl/svm_dwell.sv
hw/rtl/svm_duty.sv
hw/rtl/space_vector_modulator.sv
hw/rtl/svm_checker.sv
tb/tb_top.sv
